// File: rtl/rainbow_pixel_pattern_generator_defines.svh
// Assertion macros shared by the pattern generator.
// Both macros sample on clk and are switched off while arst_n is low.
`ifndef RAINBOW_PIXEL_PATTERN_GENERATOR_DEFINES_SVH
`define RAINBOW_PIXEL_PATTERN_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rpg_pkg.sv
package rpg_pkg;

	// Longest strip handled; a larger pixel count is used as this value.
	localparam logic [7:0] MAX_PIXELS = 8'd255;

	// Input transaction kinds.
	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_STEP    = 2'd1;
	localparam logic [1:0] KIND_REQUEST = 2'd2;

	// Pattern modes.
	localparam logic [1:0] MODE_SINGLE = 2'd0;
	localparam logic [1:0] MODE_DOUBLE = 2'd1;
	localparam logic [1:0] MODE_ROTATE = 2'd2;
	localparam logic [1:0] MODE_RISE   = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_DELAY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRIGHT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_POINT    = 3'd4;
	localparam int unsigned CFG_DATA_W = 16;

	// Timers.
	localparam int unsigned STEP_W   = 11;
	localparam int unsigned CHANGE_W = 16;
	localparam logic [STEP_W-1:0]   STEP_SAT    = 11'd2047;
	localparam logic [STEP_W-1:0]   DIM_OFF_MS  = 11'd1500;
	localparam logic [CHANGE_W-1:0] CHANGE_SAT  = 16'hFFFF;

	// Hue and brightness scale factors (153 is 255 scaled by 0.6).
	localparam logic [15:0] FULL_SPAN   = 16'd255;
	localparam logic [15:0] ROTATE_SPAN = 16'd153;

	// Serial divider geometry.
	localparam int unsigned DVD_W = 16;
	localparam int unsigned DSR_W = 8;
	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	// Division by 1000 as a multiplication by ceil(2^30 / 1000) and a shift.
	localparam int unsigned PROD_W      = STEP_W + 8;
	localparam int unsigned RECIP_W     = 21;
	localparam int unsigned RECIP_SHIFT = 30;
	localparam int unsigned DIM_W       = PROD_W + RECIP_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_K = 21'd1073742;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_DIM_MUL,
		ST_DIM_SCALE,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic mul_en;
		logic scale_en;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_request;
		logic div_done;
	} ctrl_stat_t;

endpackage

// File: rtl/rainbow_pixel_pattern_generator.sv
// A pixel request steps through the divide, dimming multiply, dimming scale and
// finish states; finish holds while a waiting result is stalled. No new transaction
// is taken until a request is through; ticks and step events end in the cycle taken.
// A finished result waits in the output register while the next transaction is taken.
// Reset (arst_n low, asynchronous) clears all configuration to its defaults (pixel
// count one), the timers, the start hue, the frame flag and the output valid flag.
`include "rainbow_pixel_pattern_generator_defines.svh"

module rainbow_pixel_pattern_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [rpg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rpg_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Input channel.
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      kind,
	input  logic [7:0]                      pixel_index,
	input  logic                            first_of_frame,
	input  logic                            last_of_frame,
	// Result channel.
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_index,
	output logic [7:0]                      hue,
	output logic [7:0]                      brightness,
	output logic                            write_pixel
);

	// The controller steps each transaction through its phases; the datapath holds
	// every register of the pattern and the arithmetic. They talk only through
	// the command and status structures below.
	rpg_pkg::ctrl_cmd_t  cmd;
	rpg_pkg::ctrl_stat_t stat;

	rpg_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Each pixel request runs two divisions side by side, one for the hue and one
	// for the undimmed brightness. The fade after a step is then a multiply by the
	// elapsed time and a reciprocal multiply that stands in for the division by a
	// thousand milliseconds. Ticks and step events only move the timers.
	rpg_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.pixel_index    (pixel_index),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.out_index      (out_index),
		.hue            (hue),
		.brightness     (brightness),
		.write_pixel    (write_pixel)
	);

	// A tick, a step or an unused kind is finished in the cycle it is taken.
	`RPG_ASSERT_NEXT(a_short_kind_ready, in_valid && !in_stall && kind != rpg_pkg::KIND_REQUEST, !in_stall, "non-request transaction held the input channel")

	// A pixel request occupies the block for its whole computation.
	`RPG_ASSERT_NEXT(a_request_busy, in_valid && !in_stall && kind == rpg_pkg::KIND_REQUEST, in_stall && !cmd.out_load, "pixel request did not occupy the block")

	// A new result is only written into a free or draining output register.
	`RPG_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || !out_stall, "waiting result overwritten")

endmodule

// File: rtl/rpg_divider.sv
// Restoring divider, one quotient bit per cycle. A zero divisor gives zero.
module rpg_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rpg_pkg::DVD_W-1:0]      dividend,
	input  logic [rpg_pkg::DSR_W-1:0]      divisor,
	output logic [rpg_pkg::DVD_W-1:0]      quotient,
	output logic                           done
);

	logic [rpg_pkg::CNT_W-1:0] cnt_q;
	logic [rpg_pkg::DVD_W-1:0] quo_q;
	logic [rpg_pkg::DSR_W-1:0] rem_q;
	logic [rpg_pkg::DSR_W-1:0] dsr_q;
	logic [rpg_pkg::DSR_W:0]   trial;
	logic [rpg_pkg::DSR_W:0]   trial_sub;
	logic                      fits;

	always_comb begin
		trial     = {rem_q, quo_q[rpg_pkg::DVD_W-1]};
		trial_sub = trial - {1'b0, dsr_q};
		fits      = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= rpg_pkg::CNT_W'(rpg_pkg::DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - rpg_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial_sub[rpg_pkg::DSR_W-1:0] : trial[rpg_pkg::DSR_W-1:0];
			quo_q <= {quo_q[rpg_pkg::DVD_W-2:0], fits};
		end
	end

	assign quotient = (dsr_q == '0) ? '0 : quo_q;
	assign done     = (cnt_q == '0);

endmodule

// File: rtl/rpg_datapath.sv
// Configuration, timers, frame state, operand set-up, two dividers and the
// brightness dimming arithmetic, plus the result payload registers.
module rpg_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rpg_pkg::ctrl_cmd_t                  cmd,
	output rpg_pkg::ctrl_stat_t                 stat,
	input  logic                                cfg_we,
	input  logic [rpg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rpg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [1:0]                          kind,
	input  logic [7:0]                          pixel_index,
	input  logic                                first_of_frame,
	input  logic                                last_of_frame,
	output logic [7:0]                          out_index,
	output logic [7:0]                          hue,
	output logic [7:0]                          brightness,
	output logic                                write_pixel
);

	// Configuration registers.
	logic [1:0]                     mode_q;
	logic [rpg_pkg::CHANGE_W-1:0]   delay_q;
	logic [7:0]                     min_q;
	logic [7:0]                     count_q;
	logic [7:0]                     half_q;

	// Timers and frame state.
	logic [rpg_pkg::STEP_W-1:0]     since_step_q;
	logic [rpg_pkg::CHANGE_W-1:0]   since_change_q;
	logic [7:0]                     start_hue_q;
	logic                           frame_updates_q;

	// Per-request operands held while the request is worked on.
	logic [7:0]                     index_q;
	logic                           inside_q;
	logic                           wr_q;
	logic [7:0]                     base_q;
	logic                           dark_q;
	logic [rpg_pkg::STEP_W-1:0]     step_q;
	logic [7:0]                     v_q;
	logic [rpg_pkg::PROD_W-1:0]     prod_q;
	logic [rpg_pkg::DIM_W-1:0]      dim_q;

	logic                           animated;
	logic [7:0]                     n;
	logic                           lower;
	logic [7:0]                     d;
	logic [rpg_pkg::DVD_W-1:0]      i_full;
	logic [rpg_pkg::DVD_W-1:0]      i_rot;
	logic [rpg_pkg::DVD_W-1:0]      d_full;
	logic [rpg_pkg::DVD_W-1:0]      hue_dvd;
	logic [7:0]                     hue_dsr;
	logic [7:0]                     val_dsr;
	logic                           fu_new;
	logic                           change_due;
	logic [rpg_pkg::DVD_W-1:0]      hue_quot;
	logic [rpg_pkg::DVD_W-1:0]      val_quot;
	logic                           hue_done;
	logic                           val_done;
	logic [7:0]                     v_floor;
	logic [7:0]                     dim_left;
	logic [7:0]                     bright_calc;
	logic [rpg_pkg::PROD_W+rpg_pkg::RECIP_W-1:0] recip_prod;

	// Operand set-up for a pixel request, taken from the input fields.
	always_comb begin
		animated   = mode_q[1];
		n          = (count_q > rpg_pkg::MAX_PIXELS) ? rpg_pkg::MAX_PIXELS : count_q;
		lower      = pixel_index < half_q;
		d          = lower ? pixel_index : (n - 8'd1 - pixel_index);
		i_full     = rpg_pkg::DVD_W'(pixel_index) * rpg_pkg::FULL_SPAN;
		i_rot      = rpg_pkg::DVD_W'(pixel_index) * rpg_pkg::ROTATE_SPAN;
		d_full     = rpg_pkg::DVD_W'(d) * rpg_pkg::FULL_SPAN;
		val_dsr    = lower ? half_q : (n - half_q);
		change_due = since_change_q >= delay_q;
		fu_new     = first_of_frame ? (animated && change_due) : frame_updates_q;
		case (mode_q)
			rpg_pkg::MODE_SINGLE: begin
				hue_dvd = i_full;
				hue_dsr = n;
			end
			rpg_pkg::MODE_DOUBLE: begin
				hue_dvd = d_full;
				hue_dsr = lower ? half_q : (n - half_q - 8'd1);
			end
			rpg_pkg::MODE_ROTATE: begin
				hue_dvd = i_rot;
				hue_dsr = n;
			end
			default: begin
				hue_dvd = d_full;
				hue_dsr = n;
			end
		endcase
	end

	rpg_divider u_hue_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (hue_dvd),
		.divisor  (hue_dsr),
		.quotient (hue_quot),
		.done     (hue_done)
	);

	rpg_divider u_val_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (d_full),
		.divisor  (val_dsr),
		.quotient (val_quot),
		.done     (val_done)
	);

	assign stat.is_request = (kind == rpg_pkg::KIND_REQUEST);
	assign stat.div_done   = hue_done && val_done;

	// Configuration, timers and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= rpg_pkg::MODE_SINGLE;
			delay_q         <= '0;
			min_q           <= '0;
			count_q         <= 8'd1;
			half_q          <= '0;
			since_step_q    <= '0;
			since_change_q  <= '0;
			start_hue_q     <= '0;
			frame_updates_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rpg_pkg::CFG_PATTERN_MODE: mode_q  <= cfg_data[1:0];
					rpg_pkg::CFG_CHANGE_DELAY: delay_q <= cfg_data;
					rpg_pkg::CFG_MIN_BRIGHT:   min_q   <= cfg_data[7:0];
					rpg_pkg::CFG_PIXEL_COUNT:  count_q <= cfg_data[7:0];
					rpg_pkg::CFG_HALF_POINT:   half_q  <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				case (kind)
					rpg_pkg::KIND_TICK: begin
						if (since_step_q != rpg_pkg::STEP_SAT) begin
							since_step_q <= since_step_q + rpg_pkg::STEP_W'(1);
						end
						if (since_change_q != rpg_pkg::CHANGE_SAT) begin
							since_change_q <= since_change_q + rpg_pkg::CHANGE_W'(1);
						end
					end
					rpg_pkg::KIND_STEP: begin
						since_step_q <= '0;
					end
					rpg_pkg::KIND_REQUEST: begin
						if (first_of_frame && animated && change_due) begin
							since_change_q <= '0;
						end
						if (last_of_frame) begin
							frame_updates_q <= 1'b0;
							if (animated && fu_new) begin
								if (mode_q == rpg_pkg::MODE_ROTATE) begin
									start_hue_q <= start_hue_q - 8'd1;
								end else begin
									start_hue_q <= start_hue_q + 8'd1;
								end
							end
						end else begin
							frame_updates_q <= fu_new;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Brightness: floor at the minimum, then fade by elapsed time since the step; past DIM_OFF_MS it is the minimum.
	always_comb begin
		v_floor     = (val_quot[7:0] < min_q) ? min_q : val_quot[7:0];
		recip_prod  = (rpg_pkg::PROD_W + rpg_pkg::RECIP_W)'(prod_q)
			* (rpg_pkg::PROD_W + rpg_pkg::RECIP_W)'(rpg_pkg::RECIP_K);
		dim_left    = (dim_q > rpg_pkg::DIM_W'(v_q)) ? 8'd0 : (v_q - dim_q[7:0]);
		bright_calc = dark_q ? min_q : ((dim_left < min_q) ? min_q : dim_left);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			index_q  <= pixel_index;
			inside_q <= pixel_index < n;
			wr_q     <= animated ? fu_new : 1'b1;
			base_q   <= animated ? start_hue_q : 8'd0;
			dark_q   <= since_step_q > rpg_pkg::DIM_OFF_MS;
			step_q   <= since_step_q;
		end
		if (cmd.mul_en) begin
			v_q    <= v_floor;
			prod_q <= rpg_pkg::PROD_W'(step_q) * rpg_pkg::PROD_W'(v_floor - min_q);
		end
		if (cmd.scale_en) begin
			dim_q <= recip_prod[rpg_pkg::PROD_W+rpg_pkg::RECIP_W-1:rpg_pkg::RECIP_SHIFT];
		end
		if (cmd.out_load) begin
			out_index <= index_q;
			if (inside_q) begin
				hue         <= hue_quot[7:0] + base_q;
				brightness  <= bright_calc;
				write_pixel <= wr_q;
			end else begin
				hue         <= 8'd0;
				brightness  <= 8'd0;
				write_pixel <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/rpg_controller.sv
// Sequencer for one input transaction at a time, and the result valid flag.
module rpg_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  rpg_pkg::ctrl_stat_t  stat,
	output rpg_pkg::ctrl_cmd_t   cmd
);

	rpg_pkg::ctrl_state_t state_q;
	rpg_pkg::ctrl_state_t state_d;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rpg_pkg::ST_IDLE: begin
				if (in_valid && stat.is_request) begin
					state_d = rpg_pkg::ST_DIVIDE;
				end
			end
			rpg_pkg::ST_DIVIDE: begin
				if (stat.div_done) begin
					state_d = rpg_pkg::ST_DIM_MUL;
				end
			end
			rpg_pkg::ST_DIM_MUL:   state_d = rpg_pkg::ST_DIM_SCALE;
			rpg_pkg::ST_DIM_SCALE: state_d = rpg_pkg::ST_FINISH;
			rpg_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = rpg_pkg::ST_IDLE;
				end
			end
			default: state_d = rpg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != rpg_pkg::ST_IDLE);
		cmd.accept    = (state_q == rpg_pkg::ST_IDLE) && in_valid;
		cmd.div_start = (state_q == rpg_pkg::ST_IDLE) && in_valid && stat.is_request;
		cmd.mul_en    = (state_q == rpg_pkg::ST_DIM_MUL);
		cmd.scale_en  = (state_q == rpg_pkg::ST_DIM_SCALE);
		cmd.out_load  = (state_q == rpg_pkg::ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
